/* rtl/dfam_pkg.sv */
`timescale 1ns / 1ps

package dfam_pkg;

  // widest state or symbol index any configuration can need
  localparam int unsigned IDXW = 8;

  localparam logic [2:0] CMD_SET_TRANS = 3'd0;
  localparam logic [2:0] CMD_SET_ACC   = 3'd1;
  localparam logic [2:0] CMD_FILL_ROW  = 3'd2;
  localparam logic [2:0] CMD_FEED      = 3'd3;
  localparam logic [2:0] CMD_END       = 3'd4;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    OP_SET,
    OP_ACC,
    OP_FILL,
    OP_FEED,
    OP_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t        kind;
    logic            sym_ok;
    logic [IDXW-1:0] row;
    logic [IDXW-1:0] sym;
    logic            dead;
    logic [IDXW-1:0] dst;
    logic            flag;
  } op_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_RUN,
    BK_FILL,
    BK_FEED,
    BK_END
  } back_state_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

/* rtl/table_driven_dfa_matcher_unit.sv */
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// command   start in, busy out           cmd, state_index, symbol, next_state, accept_flag
// config    cfg_valid in, cfg_ready out  cfg_data (start state)
// result    result_valid out (strobe)    accepted
//
// Commands go through a 4-entry queue; busy is high while it is full.
// Set transition and set accepting are written straight from the queue head, feed
// symbol reads the table and then updates the state, fill row writes every symbol
// entry of the row, and end string reads the accepting bit and then registers the
// result. After reset the table and accepting bits are cleared, busy high meanwhile.
// The result strobe lasts one cycle; the receiver cannot stall it.

module table_driven_dfa_matcher_unit #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_SYMBOLS = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        cmd,
  input  logic [3:0]        state_index,
  input  logic [6:0]        symbol,
  input  logic signed [4:0] next_state,
  input  logic              accept_flag,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data,
  output logic              result_valid,
  output logic              accepted
);

  logic [3:0]             start_state;
  dfam_pkg::back_status_t status;
  dfam_pkg::op_t          push_op;
  dfam_pkg::op_t          head;
  logic                   push;
  logic                   pop;
  logic                   q_empty;
  logic                   q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_state <= cfg_data;
    end
  end

  dfam_front #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_front (
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .state_index (state_index),
    .symbol      (symbol),
    .next_state  (next_state),
    .accept_flag (accept_flag),
    .status      (status),
    .q_full      (q_full),
    .push        (push),
    .op          (push_op)
  );

  dfam_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  dfam_back #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .start_state  (start_state),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .status       (status),
    .result_valid (result_valid),
    .accepted     (accepted)
  );

endmodule

/* rtl/dfam_front.sv */
`timescale 1ns / 1ps

module dfam_front #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_SYMBOLS = 128
) (
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            cmd,
  input  logic [3:0]            state_index,
  input  logic [6:0]            symbol,
  input  logic signed [4:0]     next_state,
  input  logic                  accept_flag,
  input  dfam_pkg::back_status_t status,
  input  logic                  q_full,
  output logic                  push,
  output dfam_pkg::op_t         op
);

  logic row_ok;
  logic sym_ok;
  logic dst_live;
  logic keep;

  assign busy     = q_full || status.clearing;
  assign row_ok   = {5'b0, state_index} < 9'(NUM_STATES);
  assign sym_ok   = {2'b0, symbol} < 9'(NUM_SYMBOLS);
  assign dst_live = !next_state[4] && ({5'b0, next_state[3:0]} < 9'(NUM_STATES));

  always_comb begin
    op.kind   = dfam_pkg::OP_FEED;
    op.sym_ok = sym_ok;
    op.row    = {4'b0, state_index};
    op.sym    = {1'b0, symbol};
    op.dead   = !dst_live;
    op.dst    = dst_live ? {4'b0, next_state[3:0]} : '0;
    op.flag   = accept_flag;
    keep      = 1'b0;
    case (cmd)
      dfam_pkg::CMD_SET_TRANS: begin
        op.kind = dfam_pkg::OP_SET;
        keep    = row_ok && sym_ok;
      end
      dfam_pkg::CMD_SET_ACC: begin
        op.kind = dfam_pkg::OP_ACC;
        keep    = row_ok;
      end
      dfam_pkg::CMD_FILL_ROW: begin
        op.kind = dfam_pkg::OP_FILL;
        keep    = row_ok;
      end
      dfam_pkg::CMD_FEED: begin
        op.kind = dfam_pkg::OP_FEED;
        keep    = 1'b1;
      end
      dfam_pkg::CMD_END: begin
        op.kind = dfam_pkg::OP_END;
        keep    = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = start && !busy && keep;

endmodule

/* rtl/dfam_queue.sv */
`timescale 1ns / 1ps

module dfam_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dfam_pkg::op_t push_op,
  input  logic          pop,
  output dfam_pkg::op_t head,
  output logic          empty,
  output logic          full
);

  dfam_pkg::op_t            slots [dfam_pkg::QDEPTH];
  logic [dfam_pkg::QPW-1:0] wptr;
  logic [dfam_pkg::QPW-1:0] rptr;
  logic [dfam_pkg::QPW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (dfam_pkg::QPW + 1)'(dfam_pkg::QDEPTH));
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/dfam_back.sv */
`timescale 1ns / 1ps

module dfam_back #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_SYMBOLS = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [3:0]             start_state,
  input  dfam_pkg::op_t          head,
  input  logic                   q_empty,
  output logic                   pop,
  output dfam_pkg::back_status_t status,
  output logic                   result_valid,
  output logic                   accepted
);

  localparam int unsigned SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int unsigned YW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int unsigned AW = SW + YW;

  // entry: {dead, destination}
  logic [SW:0]   tbl [2**AW];
  logic          acc_mem [2**SW];

  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  logic [SW:0]   tbl_wdata;
  logic [AW-1:0] tbl_raddr;
  logic [SW:0]   tbl_rdata;
  logic          acc_we;
  logic [SW-1:0] acc_waddr;
  logic          acc_wdata;
  logic [SW-1:0] acc_raddr;
  logic          acc_rdata;

  dfam_pkg::back_state_t state, state_next;

  logic          at_start, at_start_next;
  logic          cur_live, cur_live_next;
  logic [SW-1:0] cur_state, cur_state_next;
  logic [SW-1:0] fill_row, fill_row_next;
  logic [SW:0]   fill_entry, fill_entry_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          end_live, end_live_next;
  logic          result_valid_next;
  logic          accepted_next;

  logic [7:0]    start8;
  logic          start_ok;
  logic          eff_live;
  logic [SW-1:0] eff_state;
  logic          feed_go;

  assign start8    = {4'b0, start_state};
  assign start_ok  = {1'b0, start8} < 9'(NUM_STATES);
  assign eff_live  = at_start ? start_ok : cur_live;
  assign eff_state = at_start ? (start_ok ? start8[SW-1:0] : '0) : cur_state;
  assign feed_go   = eff_live && head.sym_ok;

  assign status.clearing = (state == dfam_pkg::BK_CLEAR);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata <= tbl[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rdata <= acc_mem[acc_raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      dfam_pkg::BK_CLEAR: begin
        if (cnt == '1) begin
          state_next = dfam_pkg::BK_RUN;
        end
      end
      dfam_pkg::BK_RUN: begin
        if (!q_empty) begin
          case (head.kind)
            dfam_pkg::OP_FILL: state_next = dfam_pkg::BK_FILL;
            dfam_pkg::OP_FEED: state_next = feed_go ? dfam_pkg::BK_FEED : dfam_pkg::BK_RUN;
            dfam_pkg::OP_END:  state_next = dfam_pkg::BK_END;
            default:           state_next = dfam_pkg::BK_RUN;
          endcase
        end
      end
      dfam_pkg::BK_FILL: begin
        if (cnt[YW-1:0] == YW'(NUM_SYMBOLS - 1)) begin
          state_next = dfam_pkg::BK_RUN;
        end
      end
      dfam_pkg::BK_FEED: state_next = dfam_pkg::BK_RUN;
      dfam_pkg::BK_END:  state_next = dfam_pkg::BK_RUN;
      default:           state_next = dfam_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    pop               = 1'b0;
    tbl_we            = 1'b0;
    tbl_waddr         = '0;
    tbl_wdata         = '0;
    tbl_raddr         = {eff_state, head.sym[YW-1:0]};
    acc_we            = 1'b0;
    acc_waddr         = '0;
    acc_wdata         = 1'b0;
    acc_raddr         = eff_state;
    at_start_next     = at_start;
    cur_live_next     = cur_live;
    cur_state_next    = cur_state;
    fill_row_next     = fill_row;
    fill_entry_next   = fill_entry;
    cnt_next          = cnt;
    end_live_next     = end_live;
    result_valid_next = 1'b0;
    accepted_next     = accepted;
    case (state)
      dfam_pkg::BK_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = cnt;
        acc_we    = 1'b1;
        acc_waddr = cnt[AW-1:YW];
        cnt_next  = cnt + 1'b1;
      end
      dfam_pkg::BK_RUN: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head.kind)
            dfam_pkg::OP_SET: begin
              tbl_we    = 1'b1;
              tbl_waddr = {head.row[SW-1:0], head.sym[YW-1:0]};
              tbl_wdata = {head.dead, head.dst[SW-1:0]};
            end
            dfam_pkg::OP_ACC: begin
              acc_we    = 1'b1;
              acc_waddr = head.row[SW-1:0];
              acc_wdata = head.flag;
            end
            dfam_pkg::OP_FILL: begin
              fill_row_next   = head.row[SW-1:0];
              fill_entry_next = {head.dead, head.dst[SW-1:0]};
              cnt_next        = '0;
            end
            dfam_pkg::OP_FEED: begin
              at_start_next = 1'b0;
              if (!feed_go) begin
                cur_live_next  = 1'b0;
                cur_state_next = '0;
              end
            end
            dfam_pkg::OP_END: begin
              end_live_next  = eff_live;
              at_start_next  = 1'b1;
              cur_live_next  = 1'b1;
              cur_state_next = '0;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      dfam_pkg::BK_FILL: begin
        tbl_we    = 1'b1;
        tbl_waddr = {fill_row, cnt[YW-1:0]};
        tbl_wdata = fill_entry;
        cnt_next  = cnt + 1'b1;
      end
      dfam_pkg::BK_FEED: begin
        cur_live_next  = !tbl_rdata[SW];
        cur_state_next = tbl_rdata[SW] ? '0 : tbl_rdata[SW-1:0];
      end
      dfam_pkg::BK_END: begin
        result_valid_next = 1'b1;
        accepted_next     = end_live && acc_rdata;
      end
      default: begin
        cnt_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dfam_pkg::BK_CLEAR;
      at_start     <= 1'b1;
      cur_live     <= 1'b1;
      cur_state    <= '0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      at_start     <= at_start_next;
      cur_live     <= cur_live_next;
      cur_state    <= cur_state_next;
      cnt          <= cnt_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fill_row   <= fill_row_next;
    fill_entry <= fill_entry_next;
    end_live   <= end_live_next;
    accepted   <= accepted_next;
  end

endmodule

/* tb/sv/tb_table_driven_dfa_matcher_unit.sv */
`timescale 1ns / 1ps

module tb_table_driven_dfa_matcher_unit;

  localparam int NSTATE = 16;
  localparam int NSYM = 128;
  localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;
  localparam int RANDOM_ITEMS = 800;
  localparam int PHASES = 5;
  // a full queue of row fills behind one already running
  localparam int SETTLE = 5 * (NSYM + 1) + 16;

  class dfa_tracker;
    bit        dead_tbl [NSTATE][NSYM];
    bit [3:0]  dst_tbl [NSTATE][NSYM];
    bit        acc_bits [NSTATE];
    bit [3:0]  start_reg;
    bit [3:0]  cur;
    bit        cur_dead;
    bit        fresh;
    logic      verdicts_due [$];
    int        errors;

    function new();
      start_reg = '0;
      cur = '0;
      cur_dead = 1'b0;
      fresh = 1'b1;
      errors = 0;
    endfunction

    function void open_string();
      if (fresh) begin
        cur = start_reg;
        cur_dead = 1'b0;
        fresh = 1'b0;
      end
    endfunction

    function void note_request(logic [2:0] c, logic [3:0] idx, logic [6:0] sym,
                               logic signed [4:0] nxt, logic fl);
      case (c)
        dfam_pkg::CMD_SET_TRANS: begin
          dead_tbl[idx][sym] = (nxt < 0);
          dst_tbl[idx][sym] = nxt[3:0];
        end
        dfam_pkg::CMD_SET_ACC: begin
          acc_bits[idx] = fl;
        end
        dfam_pkg::CMD_FILL_ROW: begin
          for (int s = 0; s < NSYM; s++) begin
            dead_tbl[idx][s] = (nxt < 0);
            dst_tbl[idx][s] = nxt[3:0];
          end
        end
        dfam_pkg::CMD_FEED: begin
          open_string();
          if (!cur_dead) begin
            if (dead_tbl[cur][sym]) cur_dead = 1'b1;
            else cur = dst_tbl[cur][sym];
          end
        end
        dfam_pkg::CMD_END: begin
          open_string();
          verdicts_due.push_back(!cur_dead && acc_bits[cur]);
          fresh = 1'b1;
          cur_dead = 1'b0;
          cur = '0;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_verdict(logic got);
      logic want;
      if (verdicts_due.size() == 0) begin
        $error("accepted: no result expected, actual %0d", got);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want) begin
        $error("accepted: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [2:0]        cmd;
  logic [3:0]        state_index;
  logic [6:0]        symbol;
  logic signed [4:0] next_state;
  logic              accept_flag;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [3:0]        cfg_data;
  logic              result_valid;
  logic              accepted;

  dfa_tracker sb;
  logic [6:0] alphabet [4];
  int         items_done;
  bit         no_gaps;

  table_driven_dfa_matcher_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .state_index(state_index),
    .symbol(symbol),
    .next_state(next_state),
    .accept_flag(accept_flag),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .accepted(accepted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_verdict(accepted);
  end

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [6:0] pick_symbol();
    if ($urandom_range(0, 9) != 0) return alphabet[$urandom_range(0, 3)];
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic signed [4:0] pick_dest();
    if ($urandom_range(0, 99) < 12) return 5'($urandom_range(16, 31));
    return 5'($urandom_range(0, 15));
  endfunction

  task automatic issue(input logic [2:0] c, input logic [3:0] idx, input logic [6:0] sym,
                       input logic signed [4:0] nxt, input logic fl);
    int gap;
    start <= 1'b1;
    cmd <= c;
    state_index <= idx;
    symbol <= sym;
    next_state <= nxt;
    accept_flag <= fl;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(c, idx, sym, nxt, fl);
    if (c <= dfam_pkg::CMD_END) items_done++;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_start(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.start_reg = v;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_setup();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      issue(dfam_pkg::CMD_SET_TRANS, 4'($urandom_range(0, 15)), pick_symbol(), pick_dest(),
            1'($urandom_range(0, 1)));
    else if (r < 85)
      issue(dfam_pkg::CMD_SET_ACC, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
            pick_dest(), 1'($urandom_range(0, 1)));
    else if (r < 89)
      issue(dfam_pkg::CMD_FILL_ROW, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
            pick_dest(), 1'($urandom_range(0, 1)));
    else
      issue(3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)), 4'($urandom_range(0, 15)),
            7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_string();
    int n;
    n = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) random_setup();
      issue(dfam_pkg::CMD_FEED, 4'($urandom_range(0, 15)), pick_symbol(),
            5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
    end
    issue(dfam_pkg::CMD_END, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
          5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
  endtask

  task automatic directed();
    // empty string, then with start state accepting
    issue(dfam_pkg::CMD_END, 4'd0, 7'd0, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_SET_ACC, 4'd0, 7'd0, 5'sd0, 1'b1);
    issue(dfam_pkg::CMD_END, 4'd0, 7'd0, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_SET_TRANS, 4'd0, 7'd127, 5'sd15, 1'b0);
    issue(dfam_pkg::CMD_SET_ACC, 4'd15, 7'd0, 5'sd0, 1'b1);
    issue(dfam_pkg::CMD_FEED, 4'd0, 7'd127, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_END, 4'd0, 7'd0, 5'sd0, 1'b0);
    // dead state sticks until end of string
    issue(dfam_pkg::CMD_SET_TRANS, 4'd15, 7'd0, -5'sd1, 1'b0);
    issue(dfam_pkg::CMD_FEED, 4'd0, 7'd127, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_FEED, 4'd0, 7'd0, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_FEED, 4'd0, 7'd127, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_END, 4'd0, 7'd0, 5'sd0, 1'b0);
    // most negative destination
    issue(dfam_pkg::CMD_SET_TRANS, 4'd0, 7'd1, -5'sd16, 1'b0);
    issue(dfam_pkg::CMD_FEED, 4'd0, 7'd1, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_END, 4'd0, 7'd0, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_FILL_ROW, 4'd15, 7'd0, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_FEED, 4'd0, 7'd127, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_FEED, 4'd0, 7'd5, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_END, 4'd0, 7'd0, 5'sd0, 1'b0);
    // table write in the middle of a string
    issue(dfam_pkg::CMD_FEED, 4'd0, 7'd127, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_SET_TRANS, 4'd15, 7'd3, 5'sd7, 1'b0);
    issue(dfam_pkg::CMD_FEED, 4'd0, 7'd3, 5'sd0, 1'b0);
    issue(dfam_pkg::CMD_END, 4'd0, 7'd0, 5'sd0, 1'b0);
    issue(CMD_RSVD_FIRST, 4'd15, 7'd127, -5'sd1, 1'b1);
    issue(CMD_RSVD_LAST, 4'd0, 7'd0, 5'sd0, 1'b0);
  endtask

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [3:0] sval;
    int         base;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    cmd = dfam_pkg::CMD_SET_TRANS;
    state_index = '0;
    symbol = '0;
    next_state = '0;
    accept_flag = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    items_done = 0;
    no_gaps = 1'b0;
    for (int k = 0; k < 4; k++) alphabet[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    directed();
    drain();
    base = items_done;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: sval = 4'd15;
        1: sval = 4'd0;
        default: sval = 4'($urandom_range(0, 15));
      endcase
      write_start(sval);
      for (int k = 0; k < 4; k++) alphabet[k] = 7'($urandom_range(0, 127));
      while (items_done < base + (p + 1) * RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
        if ($urandom_range(0, 9) < 6) run_string();
        else random_setup();
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
